// File: sv/pfcd_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and the per-stage step of the root/division pipeline.
// Used by every design module of the pair force engine; depends on nothing.
package pfcd_pkg;

    localparam int PW   = 24;   // input field width
    localparam int DW   = 25;   // signed difference width
    localparam int MW   = 24;   // magnitude of a difference
    localparam int SQW  = 48;   // square of one component
    localparam int SUMW = 50;   // sum of three squares
    localparam int R2W  = 46;   // r2 and rc2 inside the cutoff
    localparam int RQW  = 23;   // integer square root
    localparam int CRW  = 23;   // cutoff register
    localparam int GW   = 16;   // damping gain register
    localparam int GSH  = 12;   // gain fraction bits
    localparam int DMW  = 28;   // damping magnitude
    localparam int TQW  = 40;   // 1 - r2/rc2 quotient
    localparam int TSH  = 9;    // low bits of t shifted into the m division
    localparam int MQW  = 33;   // m quotient
    localparam int UQW  = 31;   // unit vector quotient
    localparam int USH  = 30;   // unit vector fraction bits
    localparam int CMW  = MQW + UQW - USH;
    localparam int AW   = CMW + 2;
    localparam int E1W  = 43;
    localparam int E2W  = 42;
    localparam int E3W  = 44;
    localparam int EW   = E3W + 2;
    localparam int FW   = 32;
    localparam int AD_W = 3;
    localparam int DATW = 32;

    // stage schedule of the core
    localparam int SQ_N  = RQW;
    localparam int T_N   = TQW;
    localparam int M_AT  = T_N;
    localparam int M_BEG = M_AT + 1;
    localparam int M_N   = MQW;
    localparam int U_BEG = SQ_N;
    localparam int U_N   = UQW;
    localparam int E1_N  = E1W;
    localparam int E2_N  = E2W;
    localparam int E3_N  = E3W;
    localparam int NC    = M_BEG + M_N;

    localparam logic [FW-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [FW-1:0] S32_MIN = 32'h8000_0000;
    localparam logic [CRW-1:0] CUTOFF_RST = 23'd4194304;
    localparam logic [GW-1:0]  GAIN_RST   = 16'd0;

    typedef enum logic [0:0] {
        REG_CUTOFF = 1'b0,
        REG_GAIN   = 1'b1
    } t_reg;

    typedef struct packed {
        logic [2:0][PW-1:0] pa;
        logic [2:0][PW-1:0] pb;
        logic [2:0][PW-1:0] va;
        logic [2:0][PW-1:0] vb;
    } t_pair;

    typedef struct packed {
        logic                in_cut;
        logic                zero;
        logic [R2W-1:0]      r2;
        logic [2:0]          dsgn;
        logic [2:0][MW-1:0]  dmag;
        logic [2:0]          vsgn;
        logic [2:0][DMW-1:0] damp;
        logic [RQW+1:0]      sq_rem;
        logic [RQW-1:0]      sq_root;
        logic [R2W-1:0]      t_rem;
        logic [TQW-1:0]      t_q;
        logic                m_sat;
        logic [R2W-1:0]      m_rem;
        logic [MQW-1:0]      m_q;
        logic [2:0][RQW-1:0] u_rem;
        logic [2:0][UQW-1:0] u_q;
        logic [RQW-1:0]      e1_rem;
        logic [E1W-1:0]      e1_q;
        logic [R2W-1:0]      e2_rem;
        logic [E2W-1:0]      e2_q;
        logic [CRW-1:0]      e3_rem;
        logic [E3W-1:0]      e3_q;
    } t_core;

    typedef struct packed {
        logic [2:0][FW-1:0] force_v;
        logic [FW-1:0]      energy;
        logic               in_range;
        logic               clip;
    } t_res;

    // One pipeline stage: one root digit, one quotient bit of each division in flight.
    function automatic t_core f_core_step(input int k, input t_core s,
                                          input logic [R2W-1:0] c2,
                                          input logic [CRW-1:0] cr);
        t_core          o;
        logic [RQW+3:0] sq_w;
        logic [RQW+3:0] sq_try;
        logic [R2W:0]   w_wide;
        logic [RQW:0]   w_nar;
        logic [CRW:0]   w_cr;
        int             i;
        int             p;
        o = s;
        p = (k < SQ_N) ? (SQ_N - 1 - k) : 0;
        i = k - U_BEG;

        if (k < SQ_N) begin
            sq_w   = {s.sq_rem, s.r2[2*p +: 2]};
            sq_try = {2'b00, s.sq_root, 2'b01};
            if (sq_w >= sq_try) begin
                sq_w      = sq_w - sq_try;
                o.sq_root = {s.sq_root[RQW-2:0], 1'b1};
            end else begin
                o.sq_root = {s.sq_root[RQW-2:0], 1'b0};
            end
            o.sq_rem = sq_w[RQW+1:0];
        end

        if (k < T_N) begin
            w_wide = {s.t_rem, 1'b0};
            if (w_wide >= {1'b0, c2}) begin
                w_wide = w_wide - {1'b0, c2};
                o.t_q  = {s.t_q[TQW-2:0], 1'b1};
            end else begin
                o.t_q  = {s.t_q[TQW-2:0], 1'b0};
            end
            o.t_rem = w_wide[R2W-1:0];
        end

        if (k == M_AT) begin
            o.m_sat = ({(R2W+TSH-TQW)'(0), s.t_q} >= {s.r2, TSH'(0)});
            o.m_rem = {(R2W-TQW+TSH)'(0), s.t_q[TQW-1:TSH]};
            o.m_q   = '0;
        end

        if (k >= M_BEG && k < M_BEG + M_N) begin
            w_wide = {s.m_rem, s.t_q[TSH-1]};
            o.t_q  = {s.t_q[TQW-2:0], 1'b0};
            if (w_wide >= {1'b0, s.r2}) begin
                w_wide = w_wide - {1'b0, s.r2};
                o.m_q  = {s.m_q[MQW-2:0], 1'b1};
            end else begin
                o.m_q  = {s.m_q[MQW-2:0], 1'b0};
            end
            o.m_rem = w_wide[R2W-1:0];
        end

        if (k >= U_BEG && k < U_BEG + U_N) begin
            for (int j = 0; j < 3; j++) begin
                w_nar = (i == 0) ? s.dmag[j] : {s.u_rem[j], 1'b0};
                if (w_nar >= {1'b0, s.sq_root}) begin
                    w_nar     = w_nar - {1'b0, s.sq_root};
                    o.u_q[j]  = {s.u_q[j][UQW-2:0], 1'b1};
                end else begin
                    o.u_q[j]  = {s.u_q[j][UQW-2:0], 1'b0};
                end
                o.u_rem[j] = w_nar[RQW-1:0];
            end
        end

        if (k >= U_BEG && k < U_BEG + E1_N) begin
            w_nar = (i == 0) ? (RQW+1)'(1) : {s.e1_rem, 1'b0};
            if (w_nar >= {1'b0, s.sq_root}) begin
                w_nar  = w_nar - {1'b0, s.sq_root};
                o.e1_q = {s.e1_q[E1W-2:0], 1'b1};
            end else begin
                o.e1_q = {s.e1_q[E1W-2:0], 1'b0};
            end
            o.e1_rem = w_nar[RQW-1:0];
        end

        if (k >= U_BEG && k < U_BEG + E2_N) begin
            w_wide = (i == 0) ? {(R2W-RQW)'(0), s.sq_root, 1'b0} : {s.e2_rem, 1'b0};
            if (w_wide >= {1'b0, c2}) begin
                w_wide = w_wide - {1'b0, c2};
                o.e2_q = {s.e2_q[E2W-2:0], 1'b1};
            end else begin
                o.e2_q = {s.e2_q[E2W-2:0], 1'b0};
            end
            o.e2_rem = w_wide[R2W-1:0];
        end

        if (k < E3_N) begin
            w_cr = (k == 0) ? (CRW+1)'(1) : {s.e3_rem, 1'b0};
            if (w_cr >= {1'b0, cr}) begin
                w_cr   = w_cr - {1'b0, cr};
                o.e3_q = {s.e3_q[E3W-2:0], 1'b1};
            end else begin
                o.e3_q = {s.e3_q[E3W-2:0], 1'b0};
            end
            o.e3_rem = w_cr[CRW-1:0];
        end
        return o;
    endfunction

endpackage

// File: sv/pfcd_if.sv
`timescale 1ns / 1ps
// Channel interfaces: particle pair in, force result out.
// Valid/ready transfer; no dependencies.
interface pfcd_pair_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] first_pos_x;
    logic signed [23:0] first_pos_y;
    logic signed [23:0] first_pos_z;
    logic signed [23:0] second_pos_x;
    logic signed [23:0] second_pos_y;
    logic signed [23:0] second_pos_z;
    logic signed [23:0] first_vel_x;
    logic signed [23:0] first_vel_y;
    logic signed [23:0] first_vel_z;
    logic signed [23:0] second_vel_x;
    logic signed [23:0] second_vel_y;
    logic signed [23:0] second_vel_z;

    modport source (
        output valid, first_pos_x, first_pos_y, first_pos_z,
        output second_pos_x, second_pos_y, second_pos_z,
        output first_vel_x, first_vel_y, first_vel_z,
        output second_vel_x, second_vel_y, second_vel_z,
        input  ready
    );
    modport sink (
        input  valid, first_pos_x, first_pos_y, first_pos_z,
        input  second_pos_x, second_pos_y, second_pos_z,
        input  first_vel_x, first_vel_y, first_vel_z,
        input  second_vel_x, second_vel_y, second_vel_z,
        output ready
    );
endinterface

interface pfcd_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] pair_energy;
    logic               within_cutoff;
    logic               clipped;

    modport source (
        output valid, force_x, force_y, force_z, pair_energy, within_cutoff, clipped,
        input  ready
    );
    modport sink (
        input  valid, force_x, force_y, force_z, pair_energy, within_cutoff, clipped,
        output ready
    );
endinterface

// File: sv/pfcd_cfg.sv
`timescale 1ns / 1ps
// APB register file: cutoff radius and damping gain, plus registered rc^2.
// Depends on pfcd_pkg.
module pfcd_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pfcd_pkg::AD_W-1:0]    paddr,
    input  logic [pfcd_pkg::DATW-1:0]    pwdata,
    output logic [pfcd_pkg::DATW-1:0]    prdata,
    output logic                         pready,
    output logic [pfcd_pkg::CRW-1:0]     o_cr,
    output logic [pfcd_pkg::GW-1:0]      o_gain,
    output logic [pfcd_pkg::R2W-1:0]     o_c2
);
    logic [pfcd_pkg::CRW-1:0] r_cr;
    logic [pfcd_pkg::GW-1:0]  r_gain;
    logic [pfcd_pkg::R2W-1:0] r_c2;
    logic [pfcd_pkg::R2W-1:0] n_c2;
    pfcd_pkg::t_reg           w_sel;
    logic                     w_wr;

    assign w_sel = pfcd_pkg::t_reg'(paddr[2]);
    assign w_wr  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign n_c2 = {(pfcd_pkg::R2W-pfcd_pkg::CRW)'(0), r_cr}
                * {(pfcd_pkg::R2W-pfcd_pkg::CRW)'(0), r_cr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cr   <= pfcd_pkg::CUTOFF_RST;
            r_gain <= pfcd_pkg::GAIN_RST;
        end else if (w_wr) begin
            case (w_sel)
                pfcd_pkg::REG_CUTOFF: r_cr   <= pwdata[pfcd_pkg::CRW-1:0];
                pfcd_pkg::REG_GAIN:   r_gain <= pwdata[pfcd_pkg::GW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_c2 <= n_c2;
    end

    always_comb begin
        case (w_sel)
            pfcd_pkg::REG_CUTOFF: prdata = {(pfcd_pkg::DATW-pfcd_pkg::CRW)'(0), r_cr};
            pfcd_pkg::REG_GAIN:   prdata = {(pfcd_pkg::DATW-pfcd_pkg::GW)'(0), r_gain};
            default:              prdata = '0;
        endcase
    end

    assign o_cr   = r_cr;
    assign o_gain = r_gain;
    assign o_c2   = r_c2;
endmodule

// File: sv/pfcd_front.sv
`timescale 1ns / 1ps
// Front end: separations, squares, damping product, r2 and cutoff test.
// Three register stages; depends on pfcd_pkg.
module pfcd_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_vld,
    input  pfcd_pkg::t_pair           i_pair,
    input  logic [pfcd_pkg::R2W-1:0]  i_c2,
    input  logic [pfcd_pkg::GW-1:0]   i_gain,
    output logic                      o_ready,
    output logic                      o_vld,
    output pfcd_pkg::t_core           o_core
);
    localparam int DW  = pfcd_pkg::DW;
    localparam int MW  = pfcd_pkg::MW;
    localparam int PMW = pfcd_pkg::GW + MW;

    logic                 w_ld0;
    logic                 r_v0, r_v1, r_v2;
    logic [2:0][DW-1:0]   r_d, r_dv, n_d, n_dv;
    logic [2:0][pfcd_pkg::SQW-1:0] r_sq, n_sq;
    logic [2:0][MW-1:0]   r_dmag, n_dmag;
    logic [2:0]           r_dsgn, r_vsgn;
    logic [2:0][pfcd_pkg::DMW-1:0] r_damp, n_damp;
    logic [2:0][MW-1:0]   w_vmag;
    logic [2:0][PMW-1:0]  w_prod;
    logic [pfcd_pkg::SUMW-1:0] w_sum;
    pfcd_pkg::t_core      r_core, n_core;

    assign w_ld0   = i_en | ~r_v0;
    assign o_ready = w_ld0;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_d[j]  = {i_pair.pa[j][pfcd_pkg::PW-1], i_pair.pa[j]}
                    - {i_pair.pb[j][pfcd_pkg::PW-1], i_pair.pb[j]};
            n_dv[j] = {i_pair.va[j][pfcd_pkg::PW-1], i_pair.va[j]}
                    - {i_pair.vb[j][pfcd_pkg::PW-1], i_pair.vb[j]};
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_dmag[j] = r_d[j][DW-1] ? MW'(-r_d[j]) : r_d[j][MW-1:0];
            w_vmag[j] = r_dv[j][DW-1] ? MW'(-r_dv[j]) : r_dv[j][MW-1:0];
            n_sq[j]   = {(pfcd_pkg::SQW-MW)'(0), n_dmag[j]}
                      * {(pfcd_pkg::SQW-MW)'(0), n_dmag[j]};
            w_prod[j] = {(PMW-pfcd_pkg::GW)'(0), i_gain} * {(PMW-MW)'(0), w_vmag[j]};
            n_damp[j] = w_prod[j][pfcd_pkg::GSH +: pfcd_pkg::DMW];
        end
    end

    always_comb begin
        w_sum = {2'b00, r_sq[0]} + {2'b00, r_sq[1]} + {2'b00, r_sq[2]};
        n_core        = '0;
        n_core.in_cut = (w_sum < {(pfcd_pkg::SUMW-pfcd_pkg::R2W)'(0), i_c2});
        n_core.zero   = (w_sum == '0);
        n_core.r2     = w_sum[pfcd_pkg::R2W-1:0];
        n_core.dsgn   = r_dsgn;
        n_core.dmag   = r_dmag;
        n_core.vsgn   = r_vsgn;
        n_core.damp   = r_damp;
        n_core.t_rem  = i_c2 - w_sum[pfcd_pkg::R2W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_ld0) begin
                r_v0 <= i_vld;
            end
            if (i_en) begin
                r_v1 <= r_v0;
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld0) begin
            r_d  <= n_d;
            r_dv <= n_dv;
        end
        if (i_en) begin
            r_sq   <= n_sq;
            r_dmag <= n_dmag;
            r_damp <= n_damp;
            for (int j = 0; j < 3; j++) begin
                r_dsgn[j] <= r_d[j][DW-1];
                r_vsgn[j] <= r_dv[j][DW-1];
            end
            r_core <= n_core;
        end
    end

    assign o_vld  = r_v2;
    assign o_core = r_core;
endmodule

// File: sv/pfcd_core.sv
`timescale 1ns / 1ps
// Core pipeline: square root, 1 - r2/rc2, m, unit vectors and energy terms,
// one digit or quotient bit per stage. Depends on pfcd_pkg.
module pfcd_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_vld,
    input  pfcd_pkg::t_core           i_core,
    input  logic [pfcd_pkg::R2W-1:0]  i_c2,
    input  logic [pfcd_pkg::CRW-1:0]  i_cr,
    output logic                      o_vld,
    output pfcd_pkg::t_core           o_core
);
    pfcd_pkg::t_core r_core [pfcd_pkg::NC];
    pfcd_pkg::t_core n_core [pfcd_pkg::NC];
    logic            r_vld  [pfcd_pkg::NC];

    for (genvar k = 0; k < pfcd_pkg::NC; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign n_core[k] = pfcd_pkg::f_core_step(k, i_core, i_c2, i_cr);
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= i_vld;
                end
            end
        end else begin : g_next
            assign n_core[k] = pfcd_pkg::f_core_step(k, r_core[k-1], i_c2, i_cr);
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_core[k] <= n_core[k];
            end
        end
    end

    assign o_vld  = r_vld[pfcd_pkg::NC-1];
    assign o_core = r_core[pfcd_pkg::NC-1];
endmodule

// File: sv/pfcd_back.sv
`timescale 1ns / 1ps
// Back end: m times unit vector, energy sum, damping, saturation and the
// output register that drives the result channel. Depends on pfcd_pkg.
module pfcd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  pfcd_pkg::t_core  i_core,
    input  logic             i_out_ready,
    output logic             o_en,
    output logic             o_vld,
    output pfcd_pkg::t_res   o_res
);
    localparam int CMW = pfcd_pkg::CMW;
    localparam int AW  = pfcd_pkg::AW;
    localparam int EW  = pfcd_pkg::EW;
    localparam int FW  = pfcd_pkg::FW;
    localparam int PRW = pfcd_pkg::MQW + pfcd_pkg::UQW;

    logic                          r_bvld, r_ovld;
    logic [pfcd_pkg::MQW-1:0]      w_m;
    logic [2:0][PRW-1:0]           w_prod;
    logic [2:0][CMW-1:0]           r_cm, n_cm;
    logic [EW-1:0]                 w_es;
    logic [EW-FW:0]                w_ehi;
    logic                          n_esat, r_esat;
    logic [FW-1:0]                 n_energy, r_energy;
    logic                          r_in_cut, r_zero, r_msat;
    logic [2:0]                    r_dsgn, r_vsgn;
    logic [2:0][pfcd_pkg::DMW-1:0] r_damp;
    logic [2:0][AW-1:0]            w_acc;
    logic [2:0][AW-1:0]            w_c;
    logic [2:0][AW-FW:0]           w_ahi;
    logic [2:0]                    w_fsat;
    pfcd_pkg::t_res                r_res, n_res;

    assign o_en = ~r_ovld | i_out_ready;

    always_comb begin
        w_m = i_core.m_sat ? '1 : i_core.m_q;
        for (int j = 0; j < 3; j++) begin
            w_prod[j] = {(PRW-pfcd_pkg::MQW)'(0), w_m}
                      * {(PRW-pfcd_pkg::UQW)'(0), i_core.u_q[j]};
            n_cm[j]   = w_prod[j][PRW-1:pfcd_pkg::USH];
        end
        w_es  = EW'(i_core.e1_q) + EW'(i_core.e2_q) - EW'(i_core.e3_q);
        w_ehi = w_es[EW-1:FW-1];
        n_esat = ~(&w_ehi) & (|w_ehi);
        if (n_esat) begin
            n_energy = w_es[EW-1] ? pfcd_pkg::S32_MIN : pfcd_pkg::S32_MAX;
        end else begin
            n_energy = w_es[FW-1:0];
        end
    end

    always_comb begin
        n_res = '0;
        for (int j = 0; j < 3; j++) begin
            if (r_zero) begin
                w_c[j] = '0;
            end else begin
                w_c[j] = r_dsgn[j] ? -AW'(r_cm[j]) : AW'(r_cm[j]);
            end
            w_acc[j]  = w_c[j] + (r_vsgn[j] ? AW'(r_damp[j]) : -AW'(r_damp[j]));
            w_ahi[j]  = w_acc[j][AW-1:FW-1];
            w_fsat[j] = ~(&w_ahi[j]) & (|w_ahi[j]);
            if (w_fsat[j]) begin
                n_res.force_v[j] = w_acc[j][AW-1] ? pfcd_pkg::S32_MIN : pfcd_pkg::S32_MAX;
            end else begin
                n_res.force_v[j] = w_acc[j][FW-1:0];
            end
        end
        n_res.energy   = r_zero ? pfcd_pkg::S32_MAX : r_energy;
        n_res.in_range = r_in_cut;
        n_res.clip     = r_zero | (|w_fsat) | r_msat | r_esat;
        if (!r_in_cut) begin
            n_res = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvld <= 1'b0;
            r_ovld <= 1'b0;
        end else if (o_en) begin
            r_bvld <= i_vld;
            r_ovld <= r_bvld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_cm     <= n_cm;
            r_energy <= n_energy;
            r_esat   <= n_esat;
            r_in_cut <= i_core.in_cut;
            r_zero   <= i_core.zero;
            r_msat   <= i_core.m_sat;
            r_dsgn   <= i_core.dsgn;
            r_vsgn   <= i_core.vsgn;
            r_damp   <= i_core.damp;
            r_res    <= n_res;
        end
    end

    assign o_vld = r_ovld;
    assign o_res = r_res;
endmodule

// File: sv/pair_force_cutoff_damped_top.sv
`timescale 1ns / 1ps
// Pair force engine, top level. An input transfer passes 3 front stages, 74 root/division
// stages and 2 back stages before result valid. Throughput: one pair per cycle while the
// output is not stalled; the 1 - r2/rc2 and m divisions in series set the core depth.
// A stalled output holds the whole pipeline; the first stage still fills if empty.
// Reset (synchronous, active low) clears all valid bits and loads register defaults.
module pair_force_cutoff_damped_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    pfcd_pair_if.sink                  i_pair,
    pfcd_result_if.source              o_result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pfcd_pkg::AD_W-1:0]  paddr,
    input  logic [pfcd_pkg::DATW-1:0]  pwdata,
    output logic [pfcd_pkg::DATW-1:0]  prdata,
    output logic                       pready
);
    logic [pfcd_pkg::CRW-1:0] w_cr;
    logic [pfcd_pkg::GW-1:0]  w_gain;
    logic [pfcd_pkg::R2W-1:0] w_c2;
    pfcd_pkg::t_pair          w_pair;
    pfcd_pkg::t_core          w_fcore, w_ccore;
    pfcd_pkg::t_res           w_res;
    logic                     w_en, w_fvld, w_cvld, w_ovld;

    assign w_pair.pa[0] = i_pair.first_pos_x;
    assign w_pair.pa[1] = i_pair.first_pos_y;
    assign w_pair.pa[2] = i_pair.first_pos_z;
    assign w_pair.pb[0] = i_pair.second_pos_x;
    assign w_pair.pb[1] = i_pair.second_pos_y;
    assign w_pair.pb[2] = i_pair.second_pos_z;
    assign w_pair.va[0] = i_pair.first_vel_x;
    assign w_pair.va[1] = i_pair.first_vel_y;
    assign w_pair.va[2] = i_pair.first_vel_z;
    assign w_pair.vb[0] = i_pair.second_vel_x;
    assign w_pair.vb[1] = i_pair.second_vel_y;
    assign w_pair.vb[2] = i_pair.second_vel_z;

    pfcd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cr    (w_cr),
        .o_gain  (w_gain),
        .o_c2    (w_c2)
    );

    pfcd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_pair.valid),
        .i_pair  (w_pair),
        .i_c2    (w_c2),
        .i_gain  (w_gain),
        .o_ready (i_pair.ready),
        .o_vld   (w_fvld),
        .o_core  (w_fcore)
    );

    pfcd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_fvld),
        .i_core  (w_fcore),
        .i_c2    (w_c2),
        .i_cr    (w_cr),
        .o_vld   (w_cvld),
        .o_core  (w_ccore)
    );

    pfcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (w_cvld),
        .i_core      (w_ccore),
        .i_out_ready (o_result.ready),
        .o_en        (w_en),
        .o_vld       (w_ovld),
        .o_res       (w_res)
    );

    assign o_result.valid         = w_ovld;
    assign o_result.force_x       = w_res.force_v[0];
    assign o_result.force_y       = w_res.force_v[1];
    assign o_result.force_z       = w_res.force_v[2];
    assign o_result.pair_energy   = w_res.energy;
    assign o_result.within_cutoff = w_res.in_range;
    assign o_result.clipped       = w_res.clip;
endmodule

// File: sv/pfcd_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the pair force engine, bound to the top level.
// Depends on the top level's ports only.
module pfcd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_force_x,
    input logic [31:0] i_force_y,
    input logic [31:0] i_force_z,
    input logic [31:0] i_pair_energy,
    input logic        i_within_cutoff,
    input logic        i_clipped
);
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_within_cutoff) |->
            (i_force_x == 32'd0 && i_force_y == 32'd0 && i_force_z == 32'd0
             && i_pair_energy == 32'd0 && !i_clipped))
        else $error("nonzero result outside cutoff");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_force_x) && $stable(i_pair_energy)))
        else $error("stalled result changed");
endmodule

bind pair_force_cutoff_damped_top pfcd_checker u_pfcd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_pair.valid),
    .i_in_ready      (i_pair.ready),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_force_x       (o_result.force_x),
    .i_force_y       (o_result.force_y),
    .i_force_z       (o_result.force_z),
    .i_pair_energy   (o_result.pair_energy),
    .i_within_cutoff (o_result.within_cutoff),
    .i_clipped       (o_result.clipped)
);
